// ===== rtl/kpred_pkg.sv =====
// Shared types, constants and the microcode program of the Kalman predict unit.
// No dependencies; imported by every module of the block.
package kpred_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned PcW    = 5;
  localparam int unsigned WordW  = 192;
  localparam int unsigned AddrW  = 5;

  localparam logic [DataW-1:0] TransRst00 = 32'h0001_0000;
  localparam logic [DataW-1:0] TransRst01 = 32'h0001_0000;
  localparam logic [DataW-1:0] TransRst10 = 32'h0000_0000;
  localparam logic [DataW-1:0] TransRst11 = 32'h0001_0000;

  typedef logic [PcW-1:0] kp_pc_t;

  localparam kp_pc_t PcIdle = 5'd0;
  localparam kp_pc_t PcDone = 5'd23;

  typedef enum logic [2:0] {
    REG_TRANS_00 = 3'd0,
    REG_TRANS_01 = 3'd1,
    REG_TRANS_10 = 3'd2,
    REG_TRANS_11 = 3'd3,
    REG_NOISE_00 = 3'd4,
    REG_NOISE_01 = 3'd5,
    REG_NOISE_10 = 3'd6,
    REG_NOISE_11 = 3'd7
  } kp_reg_e;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_PREDICT = 1'b1
  } kp_op_e;

  typedef enum logic [1:0] {
    COND_NEXT = 2'd0,
    COND_IN   = 2'd1,
    COND_OUT  = 2'd2
  } kp_cond_e;

  typedef enum logic [3:0] {
    SRC_F00, SRC_F01, SRC_F10, SRC_F11,
    SRC_X0, SRC_X1,
    SRC_P00, SRC_P01, SRC_P10, SRC_P11,
    SRC_FP00, SRC_FP01, SRC_FP10, SRC_FP11
  } kp_src_e;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_X0, DST_X1,
    DST_P00, DST_P01, DST_P10, DST_P11,
    DST_FP00, DST_FP01, DST_FP10, DST_FP11
  } kp_dst_e;

  typedef struct packed {
    kp_cond_e cond;
    kp_pc_t   jmp;
    kp_src_e  a_sel;
    kp_src_e  b_sel;
    logic     first;
    logic     last;
    kp_dst_e  dst;
  } kp_ucode_t;

  // datapath controls issued by the sequencer
  typedef struct packed {
    kp_src_e a_sel;
    kp_src_e b_sel;
    logic    first;
    logic    last;
    kp_dst_e dst;
    logic    load;
    logic    capture;
  } kp_dp_ctrl_t;

  typedef struct packed {
    logic [3:0][DataW-1:0] trans;
    logic [3:0][DataW-1:0] noise;
  } kp_cfg_t;

  function automatic kp_ucode_t kp_mac(kp_src_e a, kp_src_e b, logic first, logic last,
                                       kp_dst_e dst);
    kp_ucode_t w;
    w.cond  = COND_NEXT;
    w.jmp   = PcIdle;
    w.a_sel = a;
    w.b_sel = b;
    w.first = first;
    w.last  = last;
    w.dst   = dst;
    return w;
  endfunction

  // One word per step: x = F*x, FP = F*P, P = FP*F^T + Q.
  function automatic kp_ucode_t kp_ucode(kp_pc_t pc);
    kp_ucode_t w;
    w = kp_mac(SRC_F00, SRC_X0, 1'b0, 1'b0, DST_NONE);
    unique case (pc)
      5'd0: begin
        w.cond = COND_IN;
        w.jmp  = PcDone;
      end
      5'd1:  w = kp_mac(SRC_F00,  SRC_X0,  1'b1, 1'b0, DST_NONE);
      5'd2:  w = kp_mac(SRC_F01,  SRC_X1,  1'b0, 1'b1, DST_X0);
      5'd3:  w = kp_mac(SRC_F10,  SRC_X0,  1'b1, 1'b0, DST_NONE);
      5'd4:  w = kp_mac(SRC_F11,  SRC_X1,  1'b0, 1'b1, DST_X1);
      5'd5:  w = kp_mac(SRC_F00,  SRC_P00, 1'b1, 1'b0, DST_NONE);
      5'd6:  w = kp_mac(SRC_F01,  SRC_P10, 1'b0, 1'b1, DST_FP00);
      5'd7:  w = kp_mac(SRC_F00,  SRC_P01, 1'b1, 1'b0, DST_NONE);
      5'd8:  w = kp_mac(SRC_F01,  SRC_P11, 1'b0, 1'b1, DST_FP01);
      5'd9:  w = kp_mac(SRC_F10,  SRC_P00, 1'b1, 1'b0, DST_NONE);
      5'd10: w = kp_mac(SRC_F11,  SRC_P10, 1'b0, 1'b1, DST_FP10);
      5'd11: w = kp_mac(SRC_F10,  SRC_P01, 1'b1, 1'b0, DST_NONE);
      5'd12: w = kp_mac(SRC_F11,  SRC_P11, 1'b0, 1'b1, DST_FP11);
      5'd13: w = kp_mac(SRC_FP00, SRC_F00, 1'b1, 1'b0, DST_NONE);
      5'd14: w = kp_mac(SRC_FP01, SRC_F01, 1'b0, 1'b1, DST_P00);
      5'd15: w = kp_mac(SRC_FP00, SRC_F10, 1'b1, 1'b0, DST_NONE);
      5'd16: w = kp_mac(SRC_FP01, SRC_F11, 1'b0, 1'b1, DST_P01);
      5'd17: w = kp_mac(SRC_FP10, SRC_F00, 1'b1, 1'b0, DST_NONE);
      5'd18: w = kp_mac(SRC_FP11, SRC_F01, 1'b0, 1'b1, DST_P10);
      5'd19: w = kp_mac(SRC_FP10, SRC_F10, 1'b1, 1'b0, DST_NONE);
      5'd20: w = kp_mac(SRC_FP11, SRC_F11, 1'b0, 1'b1, DST_P11);
      5'd23: begin
        w.cond = COND_OUT;
        w.jmp  = PcIdle;
      end
      default: w.cond = COND_NEXT;
    endcase
    return w;
  endfunction

  // saturate a 33-bit signed sum to 32 bits
  function automatic logic [DataW-1:0] kp_sat33(logic [DataW:0] v);
    logic [DataW-1:0] r;
    r = v[DataW-1:0];
    if (v[DataW] != v[DataW-1]) begin
      r = v[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== rtl/kpred_ctrl.sv =====
// Microcode sequencer: step counter, program ROM from kpred_pkg, stream handshakes.
// Depends on kpred_pkg.
module kpred_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_opcode_i,
  output logic                  in_ready_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output kpred_pkg::kp_dp_ctrl_t dp_ctrl_o
);
  import kpred_pkg::*;

  kp_pc_t    pc_q, pc_d;
  logic      out_valid_q, out_valid_d;
  kp_ucode_t uw;
  logic      in_acc;
  logic      out_free;

  always_comb begin
    uw       = kp_ucode(pc_q);
    in_acc   = (uw.cond == COND_IN) && in_valid_i;
    out_free = !out_valid_q || out_ready_i;
    pc_d     = pc_q + kp_pc_t'(1);
    unique case (uw.cond)
      COND_IN: begin
        if (!in_acc) begin
          pc_d = pc_q;
        end else if (kp_op_e'(in_opcode_i) == OP_LOAD) begin
          pc_d = uw.jmp;
        end
      end
      COND_OUT: pc_d = out_free ? uw.jmp : pc_q;
      default:  pc_d = pc_q + kp_pc_t'(1);
    endcase

    dp_ctrl_o.a_sel   = uw.a_sel;
    dp_ctrl_o.b_sel   = uw.b_sel;
    dp_ctrl_o.first   = uw.first;
    dp_ctrl_o.last    = uw.last;
    dp_ctrl_o.dst     = uw.dst;
    dp_ctrl_o.load    = in_acc && (kp_op_e'(in_opcode_i) == OP_LOAD);
    dp_ctrl_o.capture = (uw.cond == COND_OUT) && out_free;

    if (dp_ctrl_o.capture) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_ready_o  = (uw.cond == COND_IN);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PcIdle;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/kpred_dp.sv =====
// Datapath: state registers, operand select, shared multiplier, accumulator, writeback.
// Depends on kpred_pkg; driven by kpred_ctrl.
module kpred_dp #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kpred_pkg::kp_dp_ctrl_t        ctrl_i,
  input  kpred_pkg::kp_cfg_t            cfg_i,
  input  logic [kpred_pkg::WordW-1:0]   load_word_i,
  output logic [kpred_pkg::WordW-1:0]   out_word_o
);
  import kpred_pkg::*;

  localparam int unsigned ProdW = 2 * DataW;
  localparam int unsigned AccW  = ProdW + 2 - FRAC_BITS;

  logic [1:0][DataW-1:0] x_q;
  logic [3:0][DataW-1:0] p_q;
  logic [3:0][DataW-1:0] fp_q;

  logic signed [DataW-1:0] op_a, op_b;
  logic signed [ProdW-1:0] prod_q;
  logic                    first1_q, last1_q;
  kp_dst_e                 dst1_q, dst2_q;
  logic signed [AccW-1:0]  acc_q, acc_d, acc_base, acc_term;
  logic                    acc_cin;
  logic signed [ProdW-1:0] prod_sh;
  logic [DataW-1:0]        res_q, res_d, wb_val, noise_sel;
  logic [WordW-1:0]        out_q;

  function automatic logic [DataW-1:0] pick(kp_src_e s, kp_cfg_t c,
                                            logic [1:0][DataW-1:0] x,
                                            logic [3:0][DataW-1:0] p,
                                            logic [3:0][DataW-1:0] fp);
    logic [DataW-1:0] v;
    unique case (s)
      SRC_F00:  v = c.trans[0];
      SRC_F01:  v = c.trans[1];
      SRC_F10:  v = c.trans[2];
      SRC_F11:  v = c.trans[3];
      SRC_X0:   v = x[0];
      SRC_X1:   v = x[1];
      SRC_P00:  v = p[0];
      SRC_P01:  v = p[1];
      SRC_P10:  v = p[2];
      SRC_P11:  v = p[3];
      SRC_FP00: v = fp[0];
      SRC_FP01: v = fp[1];
      SRC_FP10: v = fp[2];
      SRC_FP11: v = fp[3];
      default:  v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    op_a = pick(ctrl_i.a_sel, cfg_i, x_q, p_q, fp_q);
    op_b = pick(ctrl_i.b_sel, cfg_i, x_q, p_q, fp_q);

    // truncation toward zero: floor shift plus one for negative inexact products
    prod_sh  = prod_q >>> FRAC_BITS;
    acc_term = prod_sh[AccW-1:0];
    acc_cin  = prod_q[ProdW-1] & (|prod_q[FRAC_BITS-1:0]);
    acc_base = first1_q ? '0 : acc_q;
    acc_d    = acc_base + acc_term + AccW'(acc_cin);

    res_d = acc_d[DataW-1:0];
    if (acc_d[AccW-1:DataW-1] != {(AccW-DataW+1){acc_d[AccW-1]}}) begin
      res_d = acc_d[AccW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end

    unique case (dst2_q)
      DST_P00: noise_sel = cfg_i.noise[0];
      DST_P01: noise_sel = cfg_i.noise[1];
      DST_P10: noise_sel = cfg_i.noise[2];
      DST_P11: noise_sel = cfg_i.noise[3];
      default: noise_sel = '0;
    endcase
    wb_val = kp_sat33({res_q[DataW-1], res_q} + {noise_sel[DataW-1], noise_sel});
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    acc_q  <= acc_d;
    if (last1_q) begin
      res_q <= res_d;
    end
    if (ctrl_i.capture) begin
      out_q <= {p_q, x_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first1_q <= 1'b0;
      last1_q  <= 1'b0;
      dst1_q   <= DST_NONE;
      dst2_q   <= DST_NONE;
      x_q      <= '0;
      p_q      <= '0;
      fp_q     <= '0;
    end else begin
      first1_q <= ctrl_i.first;
      last1_q  <= ctrl_i.last;
      dst1_q   <= ctrl_i.dst;
      dst2_q   <= last1_q ? dst1_q : DST_NONE;
      if (ctrl_i.load) begin
        x_q <= load_word_i[2*DataW-1:0];
        p_q <= load_word_i[WordW-1:2*DataW];
      end else begin
        unique case (dst2_q)
          DST_X0:   x_q[0]  <= wb_val;
          DST_X1:   x_q[1]  <= wb_val;
          DST_P00:  p_q[0]  <= wb_val;
          DST_P01:  p_q[1]  <= wb_val;
          DST_P10:  p_q[2]  <= wb_val;
          DST_P11:  p_q[3]  <= wb_val;
          DST_FP00: fp_q[0] <= wb_val;
          DST_FP01: fp_q[1] <= wb_val;
          DST_FP10: fp_q[2] <= wb_val;
          DST_FP11: fp_q[3] <= wb_val;
          default:  ;
        endcase
      end
    end
  end

  assign out_word_o = out_q;

endmodule

// ===== rtl/kalman_predict_2state_unit.sv =====
// Top level of the two-state Kalman predict unit: APB register bank and stream ports.
// Depends on kpred_pkg, kpred_ctrl and kpred_dp.
//
// Usage: an input word on s_axis carries the opcode in tuser (0 load, 1 predict) and
// the estimate and covariance to load in tdata. A load replaces the state; a predict
// runs x = F*x and P = F*P*F^T + Q in signed fixed point with FRAC_BITS fraction bits,
// F and Q taken from the APB registers trans_00..trans_11, noise_00..noise_11.
// Every input word yields one output word on m_axis with the new estimate and
// covariance.
// Timing: a load goes straight to the output step; a predict first runs the
// microcode program (20 multiplies through one shared 32x32 multiplier plus a
// two-stage accumulate and writeback drain). m_axis_tvalid rises as the result
// is registered. No new input word is taken while one is in progress: the next
// is accepted at the earliest in the cycle after the previous result is registered.
// Reset clears the estimate and covariance to zero, F to identity plus unit
// velocity coupling, Q to zero. A stalled m_axis holds its word; the unit can accept
// and compute the next word meanwhile and waits only to hand over that next result.
module kalman_predict_2state_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kpred_pkg::AddrW-1:0]   paddr,
  input  logic [kpred_pkg::DataW-1:0]   pwdata,
  output logic [kpred_pkg::DataW-1:0]   prdata,
  output logic                          pready,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // load_position, load_velocity, load_cov_00, load_cov_01, load_cov_10, load_cov_11
  input  logic [kpred_pkg::WordW-1:0]   s_axis_tdata,
  // opcode
  input  logic                          s_axis_tuser,
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_position, out_velocity, out_cov_00, out_cov_01, out_cov_10, out_cov_11
  output logic [kpred_pkg::WordW-1:0]   m_axis_tdata
);
  import kpred_pkg::*;

  kp_cfg_t     cfg_q;
  kp_dp_ctrl_t dp_ctrl;
  kp_reg_e     reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = kp_reg_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_TRANS_00: prdata = cfg_q.trans[0];
      REG_TRANS_01: prdata = cfg_q.trans[1];
      REG_TRANS_10: prdata = cfg_q.trans[2];
      REG_TRANS_11: prdata = cfg_q.trans[3];
      REG_NOISE_00: prdata = cfg_q.noise[0];
      REG_NOISE_01: prdata = cfg_q.noise[1];
      REG_NOISE_10: prdata = cfg_q.noise[2];
      REG_NOISE_11: prdata = cfg_q.noise[3];
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trans[0] <= TransRst00;
      cfg_q.trans[1] <= TransRst01;
      cfg_q.trans[2] <= TransRst10;
      cfg_q.trans[3] <= TransRst11;
      cfg_q.noise    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TRANS_00: cfg_q.trans[0] <= pwdata;
        REG_TRANS_01: cfg_q.trans[1] <= pwdata;
        REG_TRANS_10: cfg_q.trans[2] <= pwdata;
        REG_TRANS_11: cfg_q.trans[3] <= pwdata;
        REG_NOISE_00: cfg_q.noise[0] <= pwdata;
        REG_NOISE_01: cfg_q.noise[1] <= pwdata;
        REG_NOISE_10: cfg_q.noise[2] <= pwdata;
        REG_NOISE_11: cfg_q.noise[3] <= pwdata;
        default:      ;
      endcase
    end
  end

  kpred_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_opcode_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .dp_ctrl_o   (dp_ctrl)
  );

  kpred_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (dp_ctrl),
    .cfg_i       (cfg_q),
    .load_word_i (s_axis_tdata),
    .out_word_o  (m_axis_tdata)
  );

endmodule

// ===== tb/sv/kalman_predict_2state_unit_check.sv =====
// Checker for the two-state Kalman predict unit: mirrors the APB registers, predicts
// the result word of every accepted input word and compares it on m_axis.
// Depends on kpred_pkg; instantiated beside the block by kalman_predict_2state_unit_test.
module kalman_predict_2state_unit_check #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kpred_pkg::AddrW-1:0] paddr,
  input  logic [kpred_pkg::DataW-1:0] pwdata,
  input  logic [kpred_pkg::DataW-1:0] prdata,
  input  logic                        pready,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  // load_position, load_velocity, load_cov_00, load_cov_01, load_cov_10, load_cov_11
  input  logic [kpred_pkg::WordW-1:0] s_axis_tdata,
  // opcode
  input  logic                        s_axis_tuser,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // out_position, out_velocity, out_cov_00, out_cov_01, out_cov_10, out_cov_11
  input  logic [kpred_pkg::WordW-1:0] m_axis_tdata,
  output int                          fail_count_o,
  output int                          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import kpred_pkg::*;

  localparam longint SatHi = 64'sd2147483647;
  localparam longint SatLo = -64'sd2147483648;

  logic signed [DataW-1:0] trans_r [4];
  logic signed [DataW-1:0] noise_r [4];
  logic signed [DataW-1:0] est_r [2];
  logic signed [DataW-1:0] cov_r [4];
  logic [WordW-1:0]        predicted_words [$];
  logic [WordW-1:0]        oldest_word;
  logic [DataW-1:0]        reg_value;
  int                      mismatches = 0;

  function automatic string field_name(int f);
    case (f)
      0:       return "out_position";
      1:       return "out_velocity";
      2:       return "out_cov_00";
      3:       return "out_cov_01";
      4:       return "out_cov_10";
      default: return "out_cov_11";
    endcase
  endfunction

  function automatic void note_failure(string msg);
    mismatches++;
    $display("%0t: %s", $time, msg);
  endfunction

  // Q16.16 product, truncated toward zero
  function automatic longint qmul(logic signed [DataW-1:0] a, logic signed [DataW-1:0] b);
    longint wa;
    longint wb;
    longint prod;
    wa = longint'(a);
    wb = longint'(b);
    prod = wa * wb;
    if (prod < 0) return -((-prod) >>> FRAC_BITS);
    return prod >>> FRAC_BITS;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > SatHi) return SatHi;
    if (v < SatLo) return SatLo;
    return v;
  endfunction

  task automatic advance_filter(input logic op, input logic [WordW-1:0] word);
    logic signed [DataW-1:0] nx [2];
    logic signed [DataW-1:0] fp [4];
    longint                  t;
    longint                  q;
    if (op == OP_LOAD) begin
      est_r[0] = word[0 +: DataW];
      est_r[1] = word[DataW +: DataW];
      for (int k = 0; k < 4; k++) cov_r[k] = word[2*DataW + DataW*k +: DataW];
    end else begin
      for (int i = 0; i < 2; i++) begin
        nx[i] = DataW'(clamp32(qmul(trans_r[2*i], est_r[0]) +
                               qmul(trans_r[2*i+1], est_r[1])));
      end
      // F*P from the old covariance
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          fp[2*i+j] = DataW'(clamp32(qmul(trans_r[2*i], cov_r[j]) +
                                     qmul(trans_r[2*i+1], cov_r[2+j])));
        end
      end
      // (F*P)*F^T + Q
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          t = clamp32(qmul(fp[2*i], trans_r[2*j]) + qmul(fp[2*i+1], trans_r[2*j+1]));
          q = longint'(noise_r[2*i+j]);
          cov_r[2*i+j] = DataW'(clamp32(t + q));
        end
      end
      est_r[0] = nx[0];
      est_r[1] = nx[1];
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_r[0] = TransRst00;
      trans_r[1] = TransRst01;
      trans_r[2] = TransRst10;
      trans_r[3] = TransRst11;
      for (int k = 0; k < 4; k++) begin
        noise_r[k] = '0;
        cov_r[k]   = '0;
      end
      est_r[0] = '0;
      est_r[1] = '0;
      predicted_words.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // output first: a word leaving now belongs to an earlier input word
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_words.size() == 0) begin
          note_failure($sformatf("result word %h with none expected", m_axis_tdata));
        end else begin
          oldest_word = predicted_words.pop_front();
          for (int f = 0; f < 6; f++) begin
            if (m_axis_tdata[DataW*f +: DataW] !== oldest_word[DataW*f +: DataW]) begin
              note_failure($sformatf("%s expected %0d got %0d", field_name(f),
                                     $signed(oldest_word[DataW*f +: DataW]),
                                     $signed(m_axis_tdata[DataW*f +: DataW])));
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_filter(s_axis_tuser, s_axis_tdata);
        predicted_words.push_back({cov_r[3], cov_r[2], cov_r[1], cov_r[0], est_r[1], est_r[0]});
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (kp_reg_e'(paddr[4:2]) < REG_NOISE_00) trans_r[paddr[3:2]] = pwdata;
          else noise_r[paddr[3:2]] = pwdata;
        end else begin
          reg_value = (kp_reg_e'(paddr[4:2]) < REG_NOISE_00) ? trans_r[paddr[3:2]]
                                                              : noise_r[paddr[3:2]];
          if (prdata !== reg_value) begin
            note_failure($sformatf("register %0d read expected %h got %h",
                                   paddr[4:2], reg_value, prdata));
          end
        end
      end
      pending_o    <= predicted_words.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ===== tb/sv/kalman_predict_2state_unit_test.sv =====
// Testbench top for kalman_predict_2state_unit: programs F and Q over APB in phases
// and streams load and predict words with random gaps on both sides.
// Depends on kpred_pkg, the block and kalman_predict_2state_unit_check.
module kalman_predict_2state_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import kpred_pkg::*;

  localparam int unsigned      FRAC_BITS    = 16;
  localparam int               ItemTarget   = 1600;
  localparam int               PhaseItems   = 150;
  localparam int               SettleCycles = 32;
  localparam int               LongHold     = 400;
  localparam int               CycleLimit   = 1_000_000;
  localparam logic [DataW-1:0] QOne         = 32'h0001_0000;

  typedef enum int {
    CFG_VELOCITY,
    CFG_MAX,
    CFG_MIN,
    CFG_ZERO,
    CFG_FULL,
    CFG_MILD,
    CFG_MIXED
  } cfg_kind_e;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             psel          = 1'b0;
  logic             penable       = 1'b0;
  logic             pwrite        = 1'b0;
  logic [AddrW-1:0] paddr         = '0;
  logic [DataW-1:0] pwdata        = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [WordW-1:0] s_axis_tdata  = '0;
  logic             s_axis_tuser  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [WordW-1:0] m_axis_tdata;

  int failures;
  int words_in_flight;
  int items_sent  = 0;
  int cycle_count = 0;
  int rx_hold_req = 0;
  int hold_left   = 0;
  int rx_gap      = 0;
  bit tx_steady   = 1'b0;
  bit rx_steady   = 1'b0;

  kalman_predict_2state_unit #(.FRAC_BITS(FRAC_BITS)) dut (.*);

  kalman_predict_2state_unit_check #(.FRAC_BITS(FRAC_BITS)) u_check (
    .*,
    .fail_count_o(failures),
    .pending_o   (words_in_flight)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[kalman_predict_2state_unit] ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [DataW-1:0] corner_value();
    case ($urandom_range(0, 5))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4:       return QOne;
      default: return 32'hffff_0000;
    endcase
  endfunction

  function automatic logic [DataW-1:0] rand_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r <= 2) return $urandom;
    if (r <= 6) return DataW'($urandom_range(0, 1 << 21)) - 32'h0010_0000;
    if (r <= 8) return DataW'($urandom_range(0, 1 << 25)) - 32'h0100_0000;
    return corner_value();
  endfunction

  function automatic logic [WordW-1:0] pack_load(logic [DataW-1:0] pos, logic [DataW-1:0] vel,
                                                 logic [DataW-1:0] c00, logic [DataW-1:0] c01,
                                                 logic [DataW-1:0] c10, logic [DataW-1:0] c11);
    return {c11, c10, c01, c00, vel, pos};
  endfunction

  // receiver: random stalls, steady stretches, and one long hold-off on request
  always @(posedge clk_i) begin
    if (rx_hold_req != 0) begin
      hold_left   = rx_hold_req;
      rx_hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_steady) begin
      m_axis_tready <= 1'b1;
    end else if (rx_gap != 0) begin
      rx_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 2) == 0) rx_gap = pick_gap();
    end
  end

  task automatic offer(input kp_op_e op, input logic [WordW-1:0] payload);
    int gap;
    s_axis_tuser  <= op;
    s_axis_tdata  <= payload;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold the sender until every result word is back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (words_in_flight != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic reg_access(input bit wr, input kp_reg_e idx, input logic [DataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_filter(input cfg_kind_e kind);
    logic [DataW-1:0] vals [8];
    for (int i = 0; i < 8; i++) begin
      case (kind)
        CFG_MAX:   vals[i] = 32'h7fff_ffff;
        CFG_MIN:   vals[i] = 32'h8000_0000;
        CFG_FULL:  vals[i] = $urandom;
        CFG_MILD:  vals[i] = DataW'($urandom_range(0, 1 << 18)) - 32'h0002_0000;
        CFG_MIXED: vals[i] = corner_value();
        default:   vals[i] = '0;
      endcase
    end
    if (kind == CFG_VELOCITY) begin
      vals[REG_TRANS_00] = QOne;
      vals[REG_TRANS_01] = $urandom_range(1, 1 << 16);
      vals[REG_TRANS_11] = QOne;
      vals[REG_NOISE_00] = $urandom_range(0, 1 << 12);
      vals[REG_NOISE_01] = $urandom_range(0, 1 << 8);
      vals[REG_NOISE_10] = vals[REG_NOISE_01];
      vals[REG_NOISE_11] = $urandom_range(0, 1 << 12);
    end
    for (int i = 0; i < 8; i++) reg_access(1'b1, kp_reg_e'(i), vals[i]);
    for (int i = 0; i < 8; i++) reg_access(1'b0, kp_reg_e'(i), '0);
  endtask

  // mostly a load followed by a run of predicts; predict payloads are junk
  task automatic run_phase(input int n);
    int count;
    int reps;
    count = 0;
    while (count < n) begin
      offer(OP_LOAD, pack_load(rand_value(), rand_value(), rand_value(),
                               rand_value(), rand_value(), rand_value()));
      count++;
      reps = $urandom_range(1, 8);
      repeat (reps) begin
        offer(OP_PREDICT, {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        count++;
      end
      if ($urandom_range(0, 39) == 0) settle();
    end
  endtask

  initial begin : stimulus
    cfg_kind_e kind;
    int        phase;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of F and Q
    offer(OP_PREDICT, '0);
    offer(OP_LOAD, pack_load(QOne, QOne, QOne, '0, '0, QOne));
    offer(OP_PREDICT, '0);
    offer(OP_PREDICT, '1);
    offer(OP_LOAD, {6{32'h7fff_ffff}});
    offer(OP_PREDICT, '0);
    offer(OP_LOAD, {6{32'h8000_0000}});
    offer(OP_PREDICT, '0);
    offer(OP_LOAD, pack_load(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                             32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
    offer(OP_PREDICT, '1);
    offer(OP_LOAD, '1);
    offer(OP_PREDICT, '0);
    offer(OP_LOAD, pack_load(32'hffff_8001, 32'h0000_7fff, 32'h0000_0003,
                             32'hffff_fffd, 32'h8000_0001, 32'h7fff_0000));
    offer(OP_PREDICT, '0);
    offer(OP_PREDICT, '0);
    offer(OP_LOAD, '0);
    offer(OP_PREDICT, '0);

    phase = 0;
    while (items_sent < ItemTarget) begin
      settle();
      if (phase <= CFG_MIXED) kind = cfg_kind_e'(phase);
      else if ($urandom_range(0, 1) == 0) kind = CFG_VELOCITY;
      else kind = cfg_kind_e'($urandom_range(CFG_VELOCITY, CFG_MIXED));
      program_filter(kind);
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      if (phase == 0) rx_hold_req = LongHold;
      run_phase(PhaseItems);
      phase++;
    end
    settle();

    if (failures == 0) begin
      $display("[kalman_predict_2state_unit] OK");
    end else begin
      $display("[kalman_predict_2state_unit] ERROR");
    end
    $finish;
  end

endmodule
